// ===== rtl/lwsm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the load window monitor.
`timescale 1ns / 1ps

package lwsm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int RING_AW     = $clog2(WINDOW_MAX);
   localparam int FILL_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int SAMPLE_BITS = 20;
   localparam int NODE_BITS   = 9;
   localparam int NODES_MAX   = 256;
   localparam int MODE_BITS   = 2;
   localparam int LEN_BITS    = 7;
   localparam int ALPHA_BITS  = 9;
   localparam int ALPHA_MAX   = 256;
   localparam int SLOT_BITS   = 7;
   localparam int SUM_BITS    = 26;
   localparam int REQ_BITS    = 21;
   localparam int CAP_BITS    = NODE_BITS + SLOT_BITS;
   localparam int PROD_BITS   = CAP_BITS + ALPHA_BITS;
   localparam int BCL_BITS    = CAP_BITS + LEN_BITS;
   localparam int NUM_BITS    = 28;
   localparam int MAG_BITS    = NUM_BITS - 1;
   localparam int REM_BITS    = LEN_BITS + 1;
   localparam int DIV_STEPS   = MAG_BITS;
   localparam int CNT_BITS    = $clog2(DIV_STEPS + 1);
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 9;

   localparam logic [CSR_AW-1:0] CSR_POLICY_MODE    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_LENGTH  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ALPHA_Q8       = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_SLOTS_PER_NODE = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_BASE_NODES     = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_TOTAL_NODES    = 3'd5;

   localparam logic [MODE_BITS-1:0] MODE_OFF        = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_PEAK_BOTH  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_AVERAGE    = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_PEAK_LIMIT = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_SUB,
      ST_WRITE,
      ST_SCAN,
      ST_EVAL_MUL,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic drop_rd;
      logic drop_sub;
      logic write;
      logic scan;
      logic eval_mul;
      logic eval;
      logic div_step;
      logic done_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_drop;
      logic scan_done;
      logic avg_fire;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/lwsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lwsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lwsm_ctrl.sv =====
// Sequencing state machine for one tick transaction.
`timescale 1ns / 1ps

module lwsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lwsm_pkg::dp_status_type status,
   output lwsm_pkg::ctrl_cmd_type  cmd
);

   lwsm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lwsm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lwsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_drop ? lwsm_pkg::ST_DROP_RD : lwsm_pkg::ST_WRITE;
            end
         end
         lwsm_pkg::ST_DROP_RD:  state_in = lwsm_pkg::ST_DROP_SUB;
         lwsm_pkg::ST_DROP_SUB: state_in = lwsm_pkg::ST_WRITE;
         lwsm_pkg::ST_WRITE:    state_in = lwsm_pkg::ST_SCAN;
         lwsm_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = lwsm_pkg::ST_EVAL_MUL;
            end
         end
         lwsm_pkg::ST_EVAL_MUL: state_in = lwsm_pkg::ST_EVAL;
         lwsm_pkg::ST_EVAL: begin
            state_in = status.avg_fire ? lwsm_pkg::ST_DIV : lwsm_pkg::ST_DONE;
         end
         lwsm_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = lwsm_pkg::ST_DONE;
            end
         end
         lwsm_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = lwsm_pkg::ST_IDLE;
            end
         end
         default: state_in = lwsm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lwsm_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         lwsm_pkg::ST_DROP_RD:  cmd.drop_rd  = 1'b1;
         lwsm_pkg::ST_DROP_SUB: cmd.drop_sub = 1'b1;
         lwsm_pkg::ST_WRITE:    cmd.write    = 1'b1;
         lwsm_pkg::ST_SCAN:     cmd.scan     = 1'b1;
         lwsm_pkg::ST_EVAL_MUL: cmd.eval_mul = 1'b1;
         lwsm_pkg::ST_EVAL:     cmd.eval     = 1'b1;
         lwsm_pkg::ST_DIV:      cmd.div_step = !status.div_done;
         lwsm_pkg::ST_DONE:     cmd.done_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/lwsm_datapath.sv =====
// Window storage, running sum, peak scan, decision logic, divider and result register.
`timescale 1ns / 1ps

module lwsm_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lwsm_pkg::ctrl_cmd_type                 cmd,
   output lwsm_pkg::dp_status_type                status,
   input  logic                                   csr_valid,
   input  logic [lwsm_pkg::CSR_AW-1:0]            csr_index,
   input  logic [lwsm_pkg::CSR_DW-1:0]            csr_data,
   input  logic [lwsm_pkg::SAMPLE_BITS-1:0]       req_pending_load,
   input  logic [lwsm_pkg::NODE_BITS-1:0]         req_active_count,
   input  logic                                   req_transition_settled,
   input  logic                                   req_popular_present,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_scale_request,
   output logic signed [lwsm_pkg::REQ_BITS-1:0]   rsp_required_slots,
   output logic [lwsm_pkg::SAMPLE_BITS-1:0]       rsp_window_peak,
   output logic [lwsm_pkg::SUM_BITS-1:0]          rsp_window_sum,
   output logic [lwsm_pkg::FILL_BITS-1:0]         rsp_window_fill
);

   localparam logic [lwsm_pkg::NODE_BITS-1:0] NODES_SAT = lwsm_pkg::NODE_BITS'(lwsm_pkg::NODES_MAX);
   localparam logic [lwsm_pkg::ALPHA_BITS-1:0] ALPHA_SAT =
      lwsm_pkg::ALPHA_BITS'(lwsm_pkg::ALPHA_MAX);
   localparam logic [lwsm_pkg::LEN_BITS-1:0] LEN_MAX = lwsm_pkg::LEN_BITS'(lwsm_pkg::WINDOW_MAX);
   localparam logic [lwsm_pkg::MAG_BITS-1:0] POS_LIMIT =
      lwsm_pkg::MAG_BITS'((1 << (lwsm_pkg::REQ_BITS - 1)) - 1);
   localparam logic [lwsm_pkg::MAG_BITS-1:0] NEG_LIMIT =
      lwsm_pkg::MAG_BITS'(1 << (lwsm_pkg::REQ_BITS - 1));
   localparam logic [lwsm_pkg::REQ_BITS-1:0] REQ_POS_SAT = {1'b0, {(lwsm_pkg::REQ_BITS-1){1'b1}}};
   localparam logic [lwsm_pkg::REQ_BITS-1:0] REQ_NEG_SAT = {1'b1, {(lwsm_pkg::REQ_BITS-1){1'b0}}};

   // configuration
   logic [lwsm_pkg::MODE_BITS-1:0]  mode_ff;
   logic [lwsm_pkg::LEN_BITS-1:0]   wlen_ff;
   logic [lwsm_pkg::ALPHA_BITS-1:0] alpha_ff;
   logic [lwsm_pkg::SLOT_BITS-1:0]  slots_ff;
   logic [lwsm_pkg::NODE_BITS-1:0]  base_ff;
   logic [lwsm_pkg::NODE_BITS-1:0]  total_ff;

   // window state
   logic [lwsm_pkg::SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic [lwsm_pkg::NODE_BITS-1:0]   nn_ff, nn_in;
   logic                             pop_ff, pop_in;
   logic [lwsm_pkg::RING_AW-1:0]     head_ff, head_in;
   logic [lwsm_pkg::FILL_BITS-1:0]   fill_ff, fill_in;
   logic [lwsm_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [lwsm_pkg::RING_AW-1:0]     phase_ff, phase_in;
   logic                             first_ff, first_in;
   logic                             stable_ff, stable_in;

   // evaluation
   logic [lwsm_pkg::CAP_BITS-1:0]    cap_ff, cap_in;
   logic [lwsm_pkg::CAP_BITS-1:0]    bcap_ff, bcap_in;
   logic [lwsm_pkg::FILL_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic                             pend_ff, pend_in;
   logic [lwsm_pkg::SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [lwsm_pkg::PROD_BITS-1:0]   prod_ff, prod_in;
   logic [lwsm_pkg::BCL_BITS-1:0]    bcl_ff, bcl_in;
   logic                             fire_ff, fire_in;
   logic [lwsm_pkg::REQ_BITS-1:0]    req_ff, req_in;
   logic                             avg_ff, avg_in;
   logic                             neg_ff, neg_in;
   logic [lwsm_pkg::MAG_BITS-1:0]    q_ff, q_in;
   logic [lwsm_pkg::REM_BITS-1:0]    rem_ff, rem_in;
   logic [lwsm_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;

   // result register
   logic                             out_valid_ff, out_valid_in;
   logic                             out_fire_ff;
   logic [lwsm_pkg::REQ_BITS-1:0]    out_req_ff;
   logic [lwsm_pkg::SAMPLE_BITS-1:0] out_peak_ff;
   logic [lwsm_pkg::SUM_BITS-1:0]    out_sum_ff;
   logic [lwsm_pkg::FILL_BITS-1:0]   out_fill_ff;

   logic [lwsm_pkg::LEN_BITS-1:0]    len_c;
   logic [lwsm_pkg::NODE_BITS-1:0]   base_sat_c, total_sat_c;
   logic [lwsm_pkg::ALPHA_BITS-1:0]  alpha_sat_c;
   logic                             ram_we, ram_re;
   logic [lwsm_pkg::RING_AW-1:0]     ram_waddr, ram_raddr;
   logic [lwsm_pkg::SAMPLE_BITS-1:0] ram_rdata;
   logic                             scan_issue;
   logic                             boundary, over, under, rule_fire, fire_c;
   logic signed [lwsm_pkg::NUM_BITS-1:0] num_c;
   logic [lwsm_pkg::REM_BITS-1:0]    rem_sh;
   logic                             rem_ge;
   logic [lwsm_pkg::REQ_BITS-1:0]    req_final;
   logic [lwsm_pkg::LEN_BITS:0]      phase_inc;

   always_comb begin
      if (wlen_ff == '0) begin
         len_c = lwsm_pkg::LEN_BITS'(1);
      end else if (wlen_ff > LEN_MAX) begin
         len_c = LEN_MAX;
      end else begin
         len_c = wlen_ff;
      end
   end

   assign base_sat_c  = (base_ff > NODES_SAT) ? NODES_SAT : base_ff;
   assign total_sat_c = (total_ff > NODES_SAT) ? NODES_SAT : total_ff;
   assign alpha_sat_c = (alpha_ff > ALPHA_SAT) ? ALPHA_SAT : alpha_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lwsm_pkg::MODE_PEAK_LIMIT;
         wlen_ff  <= lwsm_pkg::LEN_BITS'(16);
         alpha_ff <= lwsm_pkg::ALPHA_BITS'(128);
         slots_ff <= lwsm_pkg::SLOT_BITS'(4);
         base_ff  <= lwsm_pkg::NODE_BITS'(16);
         total_ff <= lwsm_pkg::NODE_BITS'(64);
      end else if (csr_valid) begin
         unique case (csr_index)
            lwsm_pkg::CSR_POLICY_MODE:    mode_ff  <= csr_data[lwsm_pkg::MODE_BITS-1:0];
            lwsm_pkg::CSR_WINDOW_LENGTH:  wlen_ff  <= csr_data[lwsm_pkg::LEN_BITS-1:0];
            lwsm_pkg::CSR_ALPHA_Q8:       alpha_ff <= csr_data[lwsm_pkg::ALPHA_BITS-1:0];
            lwsm_pkg::CSR_SLOTS_PER_NODE: slots_ff <= csr_data[lwsm_pkg::SLOT_BITS-1:0];
            lwsm_pkg::CSR_BASE_NODES:     base_ff  <= csr_data[lwsm_pkg::NODE_BITS-1:0];
            lwsm_pkg::CSR_TOTAL_NODES:    total_ff <= csr_data[lwsm_pkg::NODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sample ring
   assign scan_issue = cmd.scan && (scan_idx_ff < fill_ff);
   assign ram_we     = cmd.write;
   assign ram_waddr  = head_ff + fill_ff[lwsm_pkg::RING_AW-1:0];
   assign ram_re     = cmd.drop_rd || scan_issue;
   assign ram_raddr  = cmd.drop_rd ? head_ff : head_ff + scan_idx_ff[lwsm_pkg::RING_AW-1:0];

   lwsm_ram #(
      .WIDTH (lwsm_pkg::SAMPLE_BITS),
      .DEPTH (lwsm_pkg::WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (samp_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // decision
   assign boundary = first_ff && (phase_ff == '0) && stable_ff;
   assign over     = peak_ff > lwsm_pkg::SAMPLE_BITS'(cap_ff);
   assign under    = {peak_ff, 8'b0} < (lwsm_pkg::SAMPLE_BITS + 8)'(prod_ff);

   always_comb begin
      case (mode_ff)
         lwsm_pkg::MODE_PEAK_BOTH:  rule_fire = over || under;
         lwsm_pkg::MODE_PEAK_LIMIT: rule_fire = (over && (nn_ff < total_sat_c)) ||
                                                (under && (nn_ff > base_sat_c));
         lwsm_pkg::MODE_AVERAGE:    rule_fire = pop_ff;
         default:                   rule_fire = 1'b0;
      endcase
   end

   assign fire_c = boundary && rule_fire;
   assign num_c  = $signed({2'b0, sum_ff}) - $signed(lwsm_pkg::NUM_BITS'(bcl_ff));

   // restoring divide step
   assign rem_sh = {rem_ff[lwsm_pkg::REM_BITS-2:0], q_ff[lwsm_pkg::MAG_BITS-1]};
   assign rem_ge = rem_sh >= lwsm_pkg::REM_BITS'(len_c);

   always_comb begin
      if (!avg_ff) begin
         req_final = req_ff;
      end else if (!neg_ff) begin
         req_final = (q_ff > POS_LIMIT) ? REQ_POS_SAT : q_ff[lwsm_pkg::REQ_BITS-1:0];
      end else begin
         req_final = (q_ff > NEG_LIMIT) ? REQ_NEG_SAT : (~q_ff[lwsm_pkg::REQ_BITS-1:0] + 1'b1);
      end
   end

   assign phase_inc = {1'b0, phase_ff} + 1'b1;

   always_comb begin
      samp_in     = samp_ff;
      nn_in       = nn_ff;
      pop_in      = pop_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      phase_in    = phase_ff;
      first_in    = first_ff;
      stable_in   = stable_ff;
      cap_in      = cap_ff;
      bcap_in     = bcap_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = 1'b0;
      peak_in     = peak_ff;
      prod_in     = prod_ff;
      bcl_in      = bcl_ff;
      fire_in     = fire_ff;
      req_in      = req_ff;
      avg_in      = avg_ff;
      neg_in      = neg_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;

      if (cmd.accept) begin
         samp_in   = req_pending_load;
         nn_in     = (req_active_count > NODES_SAT) ? NODES_SAT : req_active_count;
         pop_in    = req_popular_present;
         stable_in = stable_ff || req_transition_settled;
      end
      if (cmd.drop_sub) begin
         sum_in  = sum_ff - lwsm_pkg::SUM_BITS'(ram_rdata);
         head_in = head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.write) begin
         fill_in     = fill_ff + 1'b1;
         sum_in      = sum_ff + lwsm_pkg::SUM_BITS'(samp_ff);
         cap_in      = nn_ff * slots_ff;
         bcap_in     = base_sat_c * slots_ff;
         scan_idx_in = '0;
         peak_in     = '0;
      end
      if (cmd.scan) begin
         pend_in = scan_issue;
         if (scan_issue) begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         if (pend_ff && (ram_rdata > peak_ff)) begin
            peak_in = ram_rdata;
         end
      end
      if (cmd.eval_mul) begin
         prod_in = cap_ff * alpha_sat_c;
         bcl_in  = bcap_ff * len_c;
      end
      if (cmd.eval) begin
         fire_in = fire_c;
         avg_in  = fire_c && (mode_ff == lwsm_pkg::MODE_AVERAGE);
         neg_in  = num_c[lwsm_pkg::NUM_BITS-1];
         q_in    = num_c[lwsm_pkg::NUM_BITS-1] ? lwsm_pkg::MAG_BITS'(-num_c)
                                               : lwsm_pkg::MAG_BITS'(num_c);
         rem_in  = '0;
         cnt_in  = '0;
         req_in  = fire_c ? ({1'b0, peak_ff} - lwsm_pkg::REQ_BITS'(bcap_ff)) : '0;
         if (fire_c) begin
            stable_in = 1'b0;
         end
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? (rem_sh - lwsm_pkg::REM_BITS'(len_c)) : rem_sh;
         q_in   = {q_ff[lwsm_pkg::MAG_BITS-2:0], rem_ge};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.done_load) begin
         phase_in = (phase_inc >= {1'b0, len_c}) ? '0 : phase_inc[lwsm_pkg::RING_AW-1:0];
         first_in = 1'b1;
      end
   end

   assign out_valid_in = cmd.done_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         phase_ff     <= '0;
         first_ff     <= 1'b0;
         stable_ff    <= 1'b1;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         stable_ff    <= stable_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      nn_ff       <= nn_in;
      pop_ff      <= pop_in;
      cap_ff      <= cap_in;
      bcap_ff     <= bcap_in;
      scan_idx_ff <= scan_idx_in;
      peak_ff     <= peak_in;
      prod_ff     <= prod_in;
      bcl_ff      <= bcl_in;
      fire_ff     <= fire_in;
      req_ff      <= req_in;
      avg_ff      <= avg_in;
      neg_ff      <= neg_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      if (cmd.done_load) begin
         out_fire_ff <= fire_ff;
         out_req_ff  <= req_final;
         out_peak_ff <= peak_ff;
         out_sum_ff  <= sum_ff;
         out_fill_ff <= fill_ff;
      end
   end

   assign status.need_drop = (fill_ff >= lwsm_pkg::FILL_BITS'(len_c)) && (fill_ff != '0);
   assign status.scan_done = !(scan_idx_ff < fill_ff) && !pend_ff;
   assign status.avg_fire  = fire_c && (mode_ff == lwsm_pkg::MODE_AVERAGE);
   assign status.div_done  = cnt_ff == lwsm_pkg::CNT_BITS'(lwsm_pkg::DIV_STEPS);
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_scale_request  = out_fire_ff;
   assign rsp_required_slots = $signed(out_req_ff);
   assign rsp_window_peak    = out_peak_ff;
   assign rsp_window_sum     = out_sum_ff;
   assign rsp_window_fill    = out_fill_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lwsm_pkg::FILL_BITS'(lwsm_pkg::WINDOW_MAX))
      else $error("window fill above capacity");

   a_no_fire_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_fire_ff) |-> (out_req_ff == '0))
      else $error("required slots nonzero without scale request");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.done_load |=> out_valid_ff)
      else $error("result load did not raise valid");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= lwsm_pkg::CNT_BITS'(lwsm_pkg::DIV_STEPS))
      else $error("divider step count overrun");
`endif

endmodule

// ===== rtl/load_window_scale_monitor_top.sv =====
// An accepted transaction runs through write, peak scan, multiply and evaluate, then loads its
// result; drop read and subtract come first when the oldest sample is dropped, and the divider
// runs one bit per cycle when the average rule fires. The load waits while rsp_stall holds the
// previous result; a new transaction is taken only in idle. The scan reads one ring entry a cycle.
// Reset: synchronous, active high; clears window, sum, phase, sets stable, loads register defaults.
// The sample ring itself is not cleared; only written entries are ever read.
`timescale 1ns / 1ps

module load_window_scale_monitor_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lwsm_pkg::SAMPLE_BITS-1:0]       req_pending_load,
   input  logic [lwsm_pkg::NODE_BITS-1:0]         req_active_count,
   input  logic                                   req_transition_settled,
   input  logic                                   req_popular_present,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_scale_request,
   output logic signed [lwsm_pkg::REQ_BITS-1:0]   rsp_required_slots,
   output logic [lwsm_pkg::SAMPLE_BITS-1:0]       rsp_window_peak,
   output logic [lwsm_pkg::SUM_BITS-1:0]          rsp_window_sum,
   output logic [lwsm_pkg::FILL_BITS-1:0]         rsp_window_fill,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lwsm_pkg::CSR_AW-1:0]            csr_index,
   input  logic [lwsm_pkg::CSR_DW-1:0]            csr_data
);

   lwsm_pkg::ctrl_cmd_type  cmd;
   lwsm_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   lwsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lwsm_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_valid              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_pending_load       (req_pending_load),
      .req_active_count       (req_active_count),
      .req_transition_settled (req_transition_settled),
      .req_popular_present    (req_popular_present),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_scale_request      (rsp_scale_request),
      .rsp_required_slots     (rsp_required_slots),
      .rsp_window_peak        (rsp_window_peak),
      .rsp_window_sum         (rsp_window_sum),
      .rsp_window_fill        (rsp_window_fill)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the load window scale monitor: directed and random ticks vs. a predictor.
`timescale 1ns / 1ps

module tb_top;
   import lwsm_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PRINT_LIMIT  = 100;
   localparam longint SLOTS_HI = 1048575;
   localparam longint SLOTS_LO = -1048576;
   localparam int LOAD_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int NODE_FIELD_MAX = (1 << NODE_BITS) - 1;

   typedef struct {
      logic [SAMPLE_BITS-1:0] pending_load;
      logic [NODE_BITS-1:0]   active_count;
      logic                   transition_settled;
      logic                   popular_present;
   } load_tick_t;

   typedef struct {
      logic                       scale_request;
      logic signed [REQ_BITS-1:0] required_slots;
      logic [SAMPLE_BITS-1:0]     window_peak;
      logic [SUM_BITS-1:0]        window_sum;
      logic [FILL_BITS-1:0]       window_fill;
   } scale_report_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [SAMPLE_BITS-1:0]     req_pending_load = '0;
   logic [NODE_BITS-1:0]       req_active_count = '0;
   logic                       req_transition_settled = 1'b0;
   logic                       req_popular_present = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_scale_request;
   logic signed [REQ_BITS-1:0] rsp_required_slots;
   logic [SAMPLE_BITS-1:0]     rsp_window_peak;
   logic [SUM_BITS-1:0]        rsp_window_sum;
   logic [FILL_BITS-1:0]       rsp_window_fill;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_AW-1:0]          csr_index = '0;
   logic [CSR_DW-1:0]          csr_data = '0;

   load_window_scale_monitor_top DUT (.*);

   // predictor copy of the registers
   logic [MODE_BITS-1:0]  cfg_mode  = MODE_PEAK_LIMIT;
   logic [LEN_BITS-1:0]   cfg_len   = 7'd16;
   logic [ALPHA_BITS-1:0] cfg_alpha = 9'd128;
   logic [SLOT_BITS-1:0]  cfg_slots = 7'd4;
   logic [NODE_BITS-1:0]  cfg_base  = 9'd16;
   logic [NODE_BITS-1:0]  cfg_total = 9'd64;

   // predictor window state
   logic [SAMPLE_BITS-1:0] win_ring [WINDOW_MAX];
   logic [RING_AW-1:0]     win_head = '0;
   logic [FILL_BITS-1:0]   win_fill = '0;
   logic [SUM_BITS-1:0]    win_sum = '0;
   logic [RING_AW-1:0]     win_phase = '0;
   logic                   win_started = 1'b0;
   logic                   win_stable = 1'b1;

   load_tick_t    pending_ticks [$];
   scale_report_t due_reports [$];
   load_tick_t    drive_tick;
   load_tick_t    seen_tick;
   scale_report_t want;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   bit   no_idle = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   int   stall_budget;
   int   quiet_cycles = 0;
   int   error_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint clamp_nodes(longint v);
      return (v > NODES_MAX) ? NODES_MAX : v;
   endfunction

   function automatic longint window_span();
      longint len;
      len = cfg_len;
      if (len < 1) len = 1;
      if (len > WINDOW_MAX) len = WINDOW_MAX;
      return len;
   endfunction

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void apply_register(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      case (idx)
         CSR_POLICY_MODE:    cfg_mode  = value[MODE_BITS-1:0];
         CSR_WINDOW_LENGTH:  cfg_len   = value[LEN_BITS-1:0];
         CSR_ALPHA_Q8:       cfg_alpha = value[ALPHA_BITS-1:0];
         CSR_SLOTS_PER_NODE: cfg_slots = value[SLOT_BITS-1:0];
         CSR_BASE_NODES:     cfg_base  = value[NODE_BITS-1:0];
         CSR_TOTAL_NODES:    cfg_total = value[NODE_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic scale_report_t advance_load_window(load_tick_t t);
      scale_report_t r;
      longint len, nn, slots, base_cap, alpha, cap, peak, req;
      logic fire, over, under;
      int k;
      len = window_span();
      nn = clamp_nodes(t.active_count);
      slots = cfg_slots;
      base_cap = clamp_nodes(cfg_base) * slots;
      alpha = (cfg_alpha > ALPHA_MAX) ? ALPHA_MAX : cfg_alpha;
      fire = 1'b0;
      req = 0;
      peak = 0;
      if (!win_stable && t.transition_settled) win_stable = 1'b1;
      if (win_fill >= len && win_fill > 0) begin
         win_sum = win_sum - win_ring[win_head];
         win_head = win_head + 1'b1;
         win_fill = win_fill - 1'b1;
      end
      win_ring[RING_AW'(win_head + win_fill)] = t.pending_load;
      win_fill = win_fill + 1'b1;
      win_sum = win_sum + t.pending_load;
      for (k = 0; k < win_fill; k++) begin
         if (win_ring[RING_AW'(win_head + k)] > peak) peak = win_ring[RING_AW'(win_head + k)];
      end
      if (win_started && win_phase == 0 && win_stable) begin
         cap = nn * slots;
         over = peak > cap;
         under = peak * 256 < cap * alpha;
         case (cfg_mode)
            MODE_PEAK_BOTH: begin
               fire = over || under;
               if (fire) req = peak - base_cap;
            end
            MODE_PEAK_LIMIT: begin
               fire = (over && nn < clamp_nodes(cfg_total)) ||
                      (under && nn > clamp_nodes(cfg_base));
               if (fire) req = peak - base_cap;
            end
            MODE_AVERAGE: begin
               fire = t.popular_present;
               if (fire) req = (longint'(win_sum) - base_cap * len) / len;
            end
            default: ;
         endcase
         if (fire) win_stable = 1'b0;
      end
      if (win_phase + 1 >= len) win_phase = '0;
      else win_phase = win_phase + 1'b1;
      win_started = 1'b1;
      if (req > SLOTS_HI) req = SLOTS_HI;
      if (req < SLOTS_LO) req = SLOTS_LO;
      r.scale_request = fire;
      r.required_slots = req[REQ_BITS-1:0];
      r.window_peak = peak[SAMPLE_BITS-1:0];
      r.window_sum = win_sum;
      r.window_fill = win_fill;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   // driver: one tick transaction per handshake, random gap before the next
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_ticks.size() > 0) begin
            drive_tick = pending_ticks.pop_front();
            req_pending_load <= drive_tick.pending_load;
            req_active_count <= drive_tick.active_count;
            req_transition_settled <= drive_tick.transition_settled;
            req_popular_present <= drive_tick.popular_present;
            req_valid <= 1'b1;
            req_gap <= idle_draw();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, counted down while a result is offered
   always @(negedge clock) begin
      stall_budget = rsp_taken ? idle_draw() : rsp_hold;
      rsp_stall <= (stall_budget > 0);
      rsp_hold <= (rsp_valid && stall_budget > 0) ? stall_budget - 1 : stall_budget;
   end

   // monitor and checker
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            seen_tick.pending_load = req_pending_load;
            seen_tick.active_count = req_active_count;
            seen_tick.transition_settled = req_transition_settled;
            seen_tick.popular_present = req_popular_present;
            due_reports.push_back(advance_load_window(seen_tick));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = due_reports.pop_front();
               if (rsp_scale_request !== want.scale_request)
                  report_mismatch($sformatf("scale_request got %b want %b",
                     rsp_scale_request, want.scale_request));
               if (rsp_required_slots !== want.required_slots)
                  report_mismatch($sformatf("required_slots got %0d want %0d",
                     rsp_required_slots, want.required_slots));
               if (rsp_window_peak !== want.window_peak)
                  report_mismatch($sformatf("window_peak got %0d want %0d",
                     rsp_window_peak, want.window_peak));
               if (rsp_window_sum !== want.window_sum)
                  report_mismatch($sformatf("window_sum got %0d want %0d",
                     rsp_window_sum, want.window_sum));
               if (rsp_window_fill !== want.window_fill)
                  report_mismatch($sformatf("window_fill got %0d want %0d",
                     rsp_window_fill, want.window_fill));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_register(logic [CSR_AW-1:0] idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DW-1:0];
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic load_settings(logic [MODE_BITS-1:0] mode, int len, int alpha, int slots,
                                int base, int total);
      write_register(CSR_POLICY_MODE, mode);
      write_register(CSR_WINDOW_LENGTH, len);
      write_register(CSR_ALPHA_Q8, alpha);
      write_register(CSR_SLOTS_PER_NODE, slots);
      write_register(CSR_BASE_NODES, base);
      write_register(CSR_TOTAL_NODES, total);
      @(negedge clock);
      csr_valid <= 1'b0;
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   task automatic queue_tick(int load, int nodes, bit settled, bit popular);
      load_tick_t t;
      t.pending_load = load[SAMPLE_BITS-1:0];
      t.active_count = nodes[NODE_BITS-1:0];
      t.transition_settled = settled;
      t.popular_present = popular;
      pending_ticks.push_back(t);
   endtask

   function automatic int pick_nodes();
      int lo, hi, pick;
      lo = (cfg_base < cfg_total) ? cfg_base : cfg_total;
      hi = (cfg_base < cfg_total) ? cfg_total : cfg_base;
      if (lo > 0) lo = lo - 1;
      if (hi < NODE_FIELD_MAX) hi = hi + 1;
      pick = $urandom_range(0, 9);
      case (pick)
         5, 6: return $urandom_range(0, NODE_FIELD_MAX);
         7: return cfg_base;
         8: return cfg_total;
         9: begin
            pick = $urandom_range(0, 2);
            return (pick == 0) ? 0 : (pick == 1) ? NODES_MAX : NODE_FIELD_MAX;
         end
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // window-long stretches share a load regime so underload and overload both build up
   task automatic queue_phase(int count);
      int i, left, regime, nodes, cap, low_cap, load, pick;
      left = 0;
      regime = 0;
      nodes = 0;
      cap = 0;
      low_cap = 0;
      for (i = 0; i < count; i++) begin
         if (left == 0) begin
            left = window_span();
            regime = $urandom_range(0, 4);
            nodes = pick_nodes();
            cap = clamp_nodes(nodes) * cfg_slots;
            low_cap = cap * ((cfg_alpha > ALPHA_MAX) ? ALPHA_MAX : cfg_alpha) / 256;
         end
         left--;
         case (regime)
            0: load = $urandom_range(0, low_cap);
            1: load = $urandom_range(low_cap, cap);
            2: load = $urandom_range(cap + 1, 5 * cap + 1);
            3: load = $urandom;
            default: begin
               pick = $urandom_range(0, 3);
               load = (pick == 0) ? 0 : (pick == 1) ? LOAD_MAX : (pick == 2) ? 1 : (1 << 19);
            end
         endcase
         if ($urandom_range(0, 19) == 0) load = $urandom;
         queue_tick(load & LOAD_MAX,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODE_FIELD_MAX) : nodes,
                    $urandom_range(0, 99) < 80, $urandom_range(0, 1));
      end
   endtask

   task automatic drain_results();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_valid || due_reports.size() != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // peak rule, both bounds, extreme node fields
      load_settings(MODE_PEAK_BOTH, 2, 256, 127, 511, 511);
      queue_tick(0, 0, 1, 0);
      queue_tick(LOAD_MAX, 511, 1, 1);
      queue_tick(0, 511, 1, 0);
      queue_tick(0, 256, 0, 1);
      queue_tick(0, 256, 0, 0);
      queue_tick(0, 256, 1, 0);
      queue_tick(0, 256, 1, 0);
      queue_tick(1, 1, 1, 1);
      queue_tick(1, 1, 1, 1);
      queue_tick(127, 1, 1, 0);
      queue_tick(127, 1, 1, 0);
      drain_results();

      // average rule, zero window length, saturated demand
      load_settings(MODE_AVERAGE, 0, 511, 0, 0, 1);
      queue_tick(LOAD_MAX, 0, 1, 1);
      queue_tick(LOAD_MAX, 0, 1, 1);
      queue_tick(LOAD_MAX, 0, 0, 1);
      queue_tick(LOAD_MAX, 0, 1, 0);
      queue_tick(0, 511, 1, 1);
      queue_tick(524288, 5, 1, 1);
      drain_results();

      // node-limited peak rule around both limits
      load_settings(MODE_PEAK_LIMIT, 1, 128, 4, 16, 64);
      queue_tick(1000, 63, 1, 0);
      queue_tick(1000, 64, 1, 0);
      queue_tick(0, 17, 1, 0);
      queue_tick(0, 17, 1, 0);
      queue_tick(0, 16, 1, 0);
      drain_results();

      load_settings(MODE_PEAK_LIMIT, 16, 128, 4, 16, 64);
      queue_phase(160);
      drain_results();
      load_settings(MODE_PEAK_BOTH, 1, 0, 1, 0, 1);
      queue_phase(150);
      drain_results();
      load_settings(MODE_PEAK_LIMIT, 64, 256, 64, 8, 256);
      queue_phase(200);
      drain_results();
      load_settings(MODE_AVERAGE, 0, 200, 127, 256, 256);
      queue_phase(120);
      drain_results();
      load_settings(MODE_OFF, 127, 511, 0, 511, 511);
      queue_phase(120);
      drain_results();
      load_settings(MODE_PEAK_LIMIT, 5, 300, 16, 2, 20);
      queue_phase(150);
      drain_results();
      load_settings(MODE_AVERAGE, 8, 64, 8, 4, 32);
      queue_phase(150);
      drain_results();
      load_settings(MODE_PEAK_BOTH, 32, 192, 3, 10, 100);
      queue_phase(150);
      drain_results();
      load_settings(MODE_PEAK_LIMIT, 3, 128, 127, 0, 511);
      queue_phase(150);
      drain_results();
      load_settings(MODE_PEAK_BOTH, 7, 256, 32, 64, 128);
      queue_phase(150);
      drain_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && due_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
